@@ hw/rtl/pi_aw_pkg.sv @@
// shared types and constants for the clamped pi speed controller
// no dependencies; used by pi_aw_ctrl, pi_aw_dp and pi_controller_antiwindup
package pi_aw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DRIVE_W    = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 3'd4;

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] RST_PROP_GAIN = 16'd256;
    localparam logic [CFG_DATA_W-1:0] RST_INT_GAIN  = 16'd51;
    localparam logic [CFG_DATA_W-1:0] RST_PERIOD    = 16'd66;
    localparam logic [CFG_DATA_W-1:0] RST_DRIVE_MIN = 16'h8000;
    localparam logic [CFG_DATA_W-1:0] RST_DRIVE_MAX = 16'h7FFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KD,
        S_KE,
        S_ACC,
        S_ICLAMP,
        S_KP,
        S_SUM,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_KD,
        MUL_KE,
        MUL_KP
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_INTEG,
        ACC_SUM
    } t_acc_op;

    typedef struct packed {
        logic    load_in;
        t_mul_op mul_op;
        t_acc_op acc_op;
        logic    integ_load;
        logic    drive_load;
    } t_dp_cmd;

endpackage

@@ hw/rtl/pi_aw_ctrl.sv @@
// sequencer for the pi controller: steps one request through the shared multiplier
// depends on pi_aw_pkg; drives the command struct of pi_aw_dp
module pi_aw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pi_aw_pkg::t_dp_cmd o_cmd
);

    pi_aw_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pi_aw_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.load_in    = 1'b0;
        o_cmd.mul_op     = pi_aw_pkg::MUL_NONE;
        o_cmd.acc_op     = pi_aw_pkg::ACC_HOLD;
        o_cmd.integ_load = 1'b0;
        o_cmd.drive_load = 1'b0;
        case (r_state)
            pi_aw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = pi_aw_pkg::S_KD;
                end
            end
            pi_aw_pkg::S_KD: begin
                o_cmd.mul_op = pi_aw_pkg::MUL_KD;
                n_state      = pi_aw_pkg::S_KE;
            end
            pi_aw_pkg::S_KE: begin
                o_cmd.mul_op = pi_aw_pkg::MUL_KE;
                n_state      = pi_aw_pkg::S_ACC;
            end
            pi_aw_pkg::S_ACC: begin
                o_cmd.acc_op = pi_aw_pkg::ACC_INTEG;
                n_state      = pi_aw_pkg::S_ICLAMP;
            end
            pi_aw_pkg::S_ICLAMP: begin
                o_cmd.integ_load = 1'b1;
                n_state          = pi_aw_pkg::S_KP;
            end
            pi_aw_pkg::S_KP: begin
                o_cmd.mul_op = pi_aw_pkg::MUL_KP;
                n_state      = pi_aw_pkg::S_SUM;
            end
            pi_aw_pkg::S_SUM: begin
                o_cmd.acc_op = pi_aw_pkg::ACC_SUM;
                n_state      = pi_aw_pkg::S_OUT;
            end
            pi_aw_pkg::S_OUT: begin
                // wait here only while the previous result is still held
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.drive_load = 1'b1;
                    n_state          = pi_aw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pi_aw_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.drive_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != pi_aw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_rise_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == pi_aw_pkg::S_OUT))
        else $error("result valid without finishing a request");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == pi_aw_pkg::S_KD))
        else $error("accepted request did not start the sequence");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drive_load |-> (!r_out_valid || !i_out_stall))
        else $error("pending result overwritten");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pi_aw_pkg::S_OUT && r_out_valid && i_out_stall)
            |=> (r_state == pi_aw_pkg::S_OUT && o_out_valid))
        else $error("sequence left the output stage while the result was held");
`endif

endmodule

@@ hw/rtl/pi_aw_dp.sv @@
// datapath of the pi controller: config registers, shared multiplier, integrator and clamp
// depends on pi_aw_pkg; sequenced by pi_aw_ctrl
module pi_aw_dp #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  pi_aw_pkg::t_dp_cmd                       i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_reference_speed,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_measured_speed,
    input  logic                                     i_cfg_we,
    input  logic        [pi_aw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [pi_aw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic signed [pi_aw_pkg::DRIVE_W-1:0]     o_drive_command
);

    // operand b carries either the error or the zero-extended period
    localparam int MW = (SAMPLE_WIDTH + 1 > 17) ? SAMPLE_WIDTH + 1 : 17;
    localparam int PW = 32 + MW;
    localparam int AW = PW + 9;

    logic signed [15:0]    r_kp, r_ki, r_lo, r_hi;
    logic        [15:0]    r_dt;
    logic signed [MW-1:0]  r_err;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  r_acc;
    logic signed [31:0]    r_integ;
    logic signed [pi_aw_pkg::DRIVE_W-1:0] r_drive;

    logic signed [31:0]    w_mul_a;
    logic signed [MW-1:0]  w_mul_b;
    logic signed [PW-1:0]  w_prod;
    logic signed [AW-1:0]  w_int_sh, w_prod_x, w_acc_integ, w_acc_sum;
    logic signed [AW-1:0]  w_lo, w_hi, w_clip_hi, w_clamp;
    logic signed [32:0]    w_rnd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= pi_aw_pkg::RST_PROP_GAIN;
            r_ki <= pi_aw_pkg::RST_INT_GAIN;
            r_dt <= pi_aw_pkg::RST_PERIOD;
            r_lo <= pi_aw_pkg::RST_DRIVE_MIN;
            r_hi <= pi_aw_pkg::RST_DRIVE_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pi_aw_pkg::REG_PROP_GAIN: r_kp <= i_cfg_data;
                pi_aw_pkg::REG_INT_GAIN:  r_ki <= i_cfg_data;
                pi_aw_pkg::REG_PERIOD:    r_dt <= i_cfg_data;
                pi_aw_pkg::REG_DRIVE_MIN: r_lo <= i_cfg_data;
                pi_aw_pkg::REG_DRIVE_MAX: r_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.mul_op)
            pi_aw_pkg::MUL_KD: begin
                w_mul_a = 32'(r_ki);
                w_mul_b = $signed(MW'({1'b0, r_dt}));
            end
            pi_aw_pkg::MUL_KE: begin
                w_mul_a = $signed(r_prod[31:0]);
                w_mul_b = r_err;
            end
            pi_aw_pkg::MUL_KP: begin
                w_mul_a = 32'(r_kp);
                w_mul_b = r_err;
            end
            default: begin
                w_mul_a = 32'(r_kp);
                w_mul_b = r_err;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // integrator step rounded to nearest: fold the half-lsb into the low byte
    assign w_int_sh    = $signed({{(AW-40){r_integ[31]}}, r_integ, 8'h80});
    assign w_prod_x    = AW'(r_prod);
    assign w_acc_integ = (w_int_sh + w_prod_x) >>> 8;
    assign w_acc_sum   = (w_prod_x <<< 8) + AW'(r_integ);

    // clamp order: upper limit first, then lower
    assign w_lo      = AW'(r_lo) <<< 16;
    assign w_hi      = AW'(r_hi) <<< 16;
    assign w_clip_hi = (r_acc > w_hi) ? w_hi : r_acc;
    assign w_clamp   = (w_clip_hi < w_lo) ? w_lo : w_clip_hi;

    assign w_rnd = $signed({w_clamp[31], w_clamp[31:0]}) + 33'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.integ_load) begin
            r_integ <= w_clamp[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_err <= MW'(i_reference_speed) - MW'(i_measured_speed);
        end
        if (i_cmd.mul_op != pi_aw_pkg::MUL_NONE) begin
            r_prod <= w_prod;
        end
        case (i_cmd.acc_op)
            pi_aw_pkg::ACC_INTEG: r_acc <= w_acc_integ;
            pi_aw_pkg::ACC_SUM:   r_acc <= w_acc_sum;
            default: ;
        endcase
        if (i_cmd.drive_load) begin
            r_drive <= w_rnd[31:16];
        end
    end

    assign o_drive_command = r_drive;

endmodule

@@ hw/rtl/pi_controller_antiwindup.sv @@
// top level of the pi speed controller with clamping anti-windup
// depends on pi_aw_pkg, pi_aw_ctrl and pi_aw_dp
//
// Each accepted request (reference and measured speed) yields one clamped drive
// command. The accepting cycle takes the error, then three passes through the
// single shared multiplier (32 x 17 bits at the default sample width; integral
// gain times period, times error, proportional gain times error) are interleaved
// with the integrator add, clamp, output add and clamp, and the result is loaded
// in the output step once the output register is free. The input is
// stalled while a request is in flight; a finished result sits in an output
// register so the next request can be taken while it waits, and that next request
// then holds in its last step until the earlier result is taken. Configuration
// writes take effect at once and belong only in idle periods. The integrator and
// drive saturate to [drive_min, drive_max] (upper limit tested first).
module pi_controller_antiwindup #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_reference_speed,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_measured_speed,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [pi_aw_pkg::DRIVE_W-1:0]     o_drive_command,
    input  logic                                     i_cfg_we,
    input  logic        [pi_aw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [pi_aw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pi_aw_pkg::t_dp_cmd w_cmd;

    pi_aw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    pi_aw_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_reference_speed (i_reference_speed),
        .i_measured_speed  (i_measured_speed),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_drive_command   (o_drive_command)
    );

endmodule
